>>> rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

   localparam int BASE_W = 32;
   localparam int LEN_W  = 16;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ALLOC = 2'd1,
      OP_FREE  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_POOL_BASE   = 2'd0,
      CSR_POOL_LENGTH = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN,
      ST_SPARE,
      ST_SORT_PICK,
      ST_SORT_SHIFT,
      ST_MERGE,
      ST_FREE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic [LEN_W-1:0]  len;
      logic              used;
   } region_type;

endpackage

>>> rtl/core/buffer_pool_allocator_top.sv
`timescale 1ns / 1ps
// Region-table allocator for a packet buffer pool. Each item is one operation
// (clear, allocate, free; an unused op code returns a failure) and yields one
// result item. A small sequencer steps one region per cycle through the table:
// clear and free each make at most one pass, an allocate runs a first-fit scan
// plus a spare-slot search, and a failed first attempt adds an insertion sort,
// a merge pass and a second search. The block accepts no item while an
// operation runs; a finished result waits in the output register until taken.
module buffer_pool_allocator_top #(
   parameter int REGION_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] op, [17:2] request_length, [49:18] release_address, [55:50] zero
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] granted_address, [32] status, [39:33] zero
   output logic [39:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int IW = $clog2(REGION_COUNT);
   localparam int CW = IW + 1;
   localparam logic [CW-1:0] LAST = CW'(REGION_COUNT - 1);
   localparam logic [CW-1:0] CNT  = CW'(REGION_COUNT);

   bpa_pkg::region_type tbl_ff [REGION_COUNT];
   bpa_pkg::region_type tbl_in [REGION_COUNT];
   bpa_pkg::state_type  state_ff, state_in;
   logic [31:0] pool_base_ff;
   logic [15:0] pool_len_ff;
   logic [1:0]  op_ff, op_in;
   logic [15:0] rq_ff, rq_in;
   logic [31:0] rel_ff, rel_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic        retry_ff, retry_in;
   logic        out_v_ff, out_v_in;
   logic [31:0] out_a_ff, out_a_in;
   logic        out_s_ff, out_s_in;
   bpa_pkg::region_type hold_ff, hold_in;

   bpa_pkg::region_type ri, rj, rk;
   logic [31:0] sum_base;
   logic [16:0] sum_len;

   assign req_tready = (state_ff == bpa_pkg::ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'd0, out_s_ff, out_a_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         pool_len_ff  <= '0;
      end else if (csr_we) begin
         if (csr_index == 1'(bpa_pkg::CSR_POOL_BASE)) pool_base_ff <= csr_wdata;
         else pool_len_ff <= csr_wdata[15:0];
      end
   end

   always_comb begin
      ri = tbl_ff[i_ff[IW-1:0]];
      rj = tbl_ff[j_ff[IW-1:0]];
      rk = tbl_ff[IW'(i_ff + 1'b1)];
      sum_base = ri.base + 32'(ri.len);
      sum_len  = {1'b0, ri.len} + {1'b0, rk.len};
   end

   always_comb begin
      tbl_in   = tbl_ff;
      state_in = state_ff;
      op_in = op_ff; rq_in = rq_ff; rel_in = rel_ff;
      i_in = i_ff; j_in = j_ff; retry_in = retry_ff; hold_in = hold_ff;
      out_v_in = out_v_ff && !rsp_tready;
      out_a_in = out_a_ff; out_s_in = out_s_ff;
      unique case (state_ff)
         bpa_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in  = req_tdata[1:0];
               rq_in  = req_tdata[17:2];
               rel_in = req_tdata[49:18];
               i_in = '0; j_in = '0; retry_in = 1'b0;
               unique case (bpa_pkg::op_type'(req_tdata[1:0]))
                  bpa_pkg::OP_CLEAR: state_in = bpa_pkg::ST_CLEAR;
                  bpa_pkg::OP_ALLOC: state_in = bpa_pkg::ST_SCAN;
                  bpa_pkg::OP_FREE:  state_in = bpa_pkg::ST_FREE;
                  default: begin
                     out_a_in = '0; out_s_in = 1'b1; state_in = bpa_pkg::ST_DONE;
                  end
               endcase
            end
         end
         bpa_pkg::ST_CLEAR: begin
            tbl_in[i_ff[IW-1:0]] = '0;
            if (i_ff == '0) begin
               tbl_in[0].base = pool_base_ff;
               tbl_in[0].len  = pool_len_ff;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == LAST) begin
               out_a_in = '0; out_s_in = 1'b0; state_in = bpa_pkg::ST_DONE;
            end
         end
         bpa_pkg::ST_SCAN: begin
            if (i_ff == CNT) begin
               if (retry_ff) begin
                  out_a_in = '1; out_s_in = 1'b1; state_in = bpa_pkg::ST_DONE;
               end else begin
                  i_in = CW'(1); state_in = bpa_pkg::ST_SORT_PICK;
               end
            end else if (ri.used || ri.len < rq_ff) begin
               i_in = i_ff + 1'b1;
            end else if (ri.len == rq_ff) begin
               tbl_in[i_ff[IW-1:0]].used = 1'b1;
               out_a_in = ri.base; out_s_in = 1'b0; state_in = bpa_pkg::ST_DONE;
            end else begin
               j_in = '0; state_in = bpa_pkg::ST_SPARE;
            end
         end
         bpa_pkg::ST_SPARE: begin
            if (j_ff == CNT) begin
               i_in = i_ff + 1'b1; state_in = bpa_pkg::ST_SCAN;
            end else if (j_ff != i_ff && !rj.used && rj.len == '0) begin
               tbl_in[j_ff[IW-1:0]] = '{base: ri.base, len: rq_ff, used: 1'b1};
               tbl_in[i_ff[IW-1:0]].base = ri.base + 32'(rq_ff);
               tbl_in[i_ff[IW-1:0]].len  = ri.len - rq_ff;
               out_a_in = ri.base; out_s_in = 1'b0; state_in = bpa_pkg::ST_DONE;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         bpa_pkg::ST_SORT_PICK: begin
            if (i_ff == CNT) begin
               i_in = '0; state_in = bpa_pkg::ST_MERGE;
            end else begin
               hold_in = ri; j_in = i_ff; state_in = bpa_pkg::ST_SORT_SHIFT;
            end
         end
         bpa_pkg::ST_SORT_SHIFT: begin
            // j is the hole; compare the entry just below it with the held one.
            if (j_ff != '0 && tbl_ff[IW'(j_ff - 1'b1)].base > hold_ff.base) begin
               tbl_in[j_ff[IW-1:0]] = tbl_ff[IW'(j_ff - 1'b1)];
               j_in = j_ff - 1'b1;
            end else begin
               tbl_in[j_ff[IW-1:0]] = hold_ff;
               i_in = i_ff + 1'b1; state_in = bpa_pkg::ST_SORT_PICK;
            end
         end
         bpa_pkg::ST_MERGE: begin
            if (i_ff >= LAST) begin
               i_in = '0; retry_in = 1'b1; state_in = bpa_pkg::ST_SCAN;
            end else if (!ri.used && ri.len != '0 && !rk.used &&
                         sum_base == rk.base && !sum_len[16]) begin
               tbl_in[i_ff[IW-1:0]].len = sum_len[15:0];
               tbl_in[IW'(i_ff + 1'b1)].base = '0;
               tbl_in[IW'(i_ff + 1'b1)].len  = '0;
               i_in = i_ff + CW'(2);
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         bpa_pkg::ST_FREE: begin
            if (i_ff == CNT) begin
               out_a_in = '0; out_s_in = 1'b1; state_in = bpa_pkg::ST_DONE;
            end else if (ri.used && ri.base == rel_ff) begin
               tbl_in[i_ff[IW-1:0]].used = 1'b0;
               out_a_in = '0; out_s_in = 1'b0; state_in = bpa_pkg::ST_DONE;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         bpa_pkg::ST_DONE: begin
            out_v_in = 1'b1; state_in = bpa_pkg::ST_IDLE;
         end
         default: state_in = bpa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bpa_pkg::ST_IDLE;
         out_v_ff <= 1'b0;
         for (int k = 0; k < REGION_COUNT; k++) tbl_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         tbl_ff   <= tbl_in;
      end
      op_ff <= op_in; rq_ff <= rq_in; rel_ff <= rel_in;
      i_ff <= i_in; j_ff <= j_in; retry_ff <= retry_in; hold_ff <= hold_in;
      out_a_ff <= out_a_in; out_s_ff <= out_s_in;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == bpa_pkg::ST_IDLE) else $error("ready while busy");
   a_done_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == bpa_pkg::ST_DONE |=> rsp_tvalid) else $error("result lost");
   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> op_ff != 2'(bpa_pkg::OP_NONE))
      else $error("success on unused op");
endmodule
